/* sv/lik_pkg.sv */
// Shared constants, types and small lookup functions of the Lagrange interpolation kernel.
// Depends on nothing; every other file of the kernel imports it.
package lik_pkg;

   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_FRAC_BITS   = 16;

   localparam int MAX_POINTS = 6;
   localparam int LANES      = MAX_POINTS;
   localparam int MAX_STEPS  = MAX_POINTS - 2;
   localparam int N_BITS     = 3;

   localparam logic [N_BITS-1:0] MIN_POINTS   = N_BITS'(2);
   localparam logic [N_BITS-1:0] TOP_POINTS   = N_BITS'(MAX_POINTS);
   localparam logic [N_BITS-1:0] RESET_POINTS = N_BITS'(4);

   typedef enum logic [1:0] {
      ODD_ONE,
      ODD_THREE,
      ODD_FIFTEEN
   } odd_type;

   typedef struct packed {
      logic [5:0] half;
      logic [1:0] shift;
      odd_type    odd;
      logic       neg;
   } den_type;

   function automatic logic [N_BITS-1:0] clamp_points(input logic [N_BITS-1:0] v);
      logic [N_BITS-1:0] r;
      priority if (v < MIN_POINTS) begin
         r = MIN_POINTS;
      end else if (v > TOP_POINTS) begin
         r = TOP_POINTS;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // distance of the oldest node below zero
   function automatic logic [1:0] node_offset(input logic [N_BITS-1:0] n);
      logic [N_BITS-1:0] t;
      t = (n - N_BITS'(1)) >> 1;
      return t[1:0];
   endfunction

   function automatic logic [6:0] fact(input int k);
      logic [6:0] r;
      unique case (k)
         0:       r = 7'd1;
         1:       r = 7'd1;
         2:       r = 7'd2;
         3:       r = 7'd6;
         4:       r = 7'd24;
         5:       r = 7'd120;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   // |D| = lane! * (n-1-lane)!, split into rounding half, power of two and odd part
   function automatic den_type den_lookup(input logic [N_BITS-1:0] n, input int lane);
      den_type den;
      int      rest;
      logic [6:0] mag;
      den  = '{half: 6'd0, shift: 2'd0, odd: ODD_ONE, neg: 1'b0};
      rest = int'(n) - 1 - lane;
      if (rest >= 0) begin
         mag     = 7'(int'(fact(lane)) * int'(fact(rest)));
         den.neg = rest[0];
      end else begin
         mag = 7'd0;
      end
      unique case (mag)
         7'd2: begin
            den.half  = 6'd1;
            den.shift = 2'd1;
         end
         7'd4: begin
            den.half  = 6'd2;
            den.shift = 2'd2;
         end
         7'd6: begin
            den.half  = 6'd3;
            den.shift = 2'd1;
            den.odd   = ODD_THREE;
         end
         7'd12: begin
            den.half  = 6'd6;
            den.shift = 2'd2;
            den.odd   = ODD_THREE;
         end
         7'd24: begin
            den.half  = 6'd12;
            den.shift = 2'd3;
            den.odd   = ODD_THREE;
         end
         7'd120: begin
            den.half  = 6'd60;
            den.shift = 2'd3;
            den.odd   = ODD_FIFTEEN;
         end
         default: begin
            den.odd = ODD_ONE;
         end
      endcase
      return den;
   endfunction

endpackage

/* sv/lik_ifs.sv */
// Valid/ready channel interfaces of the Lagrange interpolation kernel: config, request, response.
// Depends on lik_pkg for default widths and the point count width.
interface lik_csr_if
   import lik_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [N_BITS-1:0] num_points;

   modport source (output valid, output num_points, input ready);
   modport sink   (input valid, input num_points, output ready);
endinterface

interface lik_req_if
   import lik_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_0;
   logic signed [SAMPLE_BITS-1:0] sample_1;
   logic signed [SAMPLE_BITS-1:0] sample_2;
   logic signed [SAMPLE_BITS-1:0] sample_3;
   logic signed [SAMPLE_BITS-1:0] sample_4;
   logic signed [SAMPLE_BITS-1:0] sample_5;
   logic [FRAC_BITS:0]            frac;

   modport source (output valid, output sample_0, output sample_1, output sample_2,
                   output sample_3, output sample_4, output sample_5, output frac,
                   input ready);
   modport sink   (input valid, input sample_0, input sample_1, input sample_2,
                   input sample_3, input sample_4, input sample_5, input frac,
                   output ready);
endinterface

interface lik_rsp_if
   import lik_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] value;
   logic                          clipped;

   modport source (output valid, output value, output clipped, input ready);
   modport sink   (input valid, input value, input clipped, output ready);
endinterface

/* sv/lagrange_interpolation_kernel.sv */
// Lagrange fractional-delay interpolation kernel, 2 to 6 points, fixed point, 12-stage pipeline.
// Depends on lik_pkg and the channel interfaces in lik_ifs.sv.
//
//   channel    dir   handshake     payload
//   csr_chan   in    valid/ready   num_points
//   req_chan   in    valid/ready   sample_0 .. sample_5, frac
//   rsp_chan   out   valid/ready   value, clipped
//
// One item per cycle sustained while rsp_chan.ready stays high.
// The basis products take four multiply stages, one factor each, then divide, weight and sum.
// Reset (synchronous) empties the pipeline and sets num_points to 4; csr_chan is always ready.
// A full stage holds only while the one after it cannot advance, so bubbles close up under a stall;
// req_chan.ready follows rsp_chan.ready combinationally through that chain.
module lagrange_interpolation_kernel
   import lik_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic      clock,
   input  logic      reset,
   lik_csr_if.sink   csr_chan,
   lik_req_if.sink   req_chan,
   lik_rsp_if.source rsp_chan
);

   localparam int ST_IN       = 0;
   localparam int ST_D        = 1;
   localparam int ST_MUL_LAST = ST_D + MAX_STEPS;
   localparam int ST_DIVP     = ST_MUL_LAST + 1;
   localparam int ST_DIV      = ST_DIVP + 1;
   localparam int ST_SMUL     = ST_DIV + 1;
   localparam int ST_PAIR     = ST_SMUL + 1;
   localparam int ST_SUM      = ST_PAIR + 1;
   localparam int ST_OUT      = ST_SUM + 1;
   localparam int NUM_STG     = ST_OUT + 1;

   localparam int D_BITS    = FRAC_BITS + 4;
   localparam int C_BITS    = D_BITS - FRAC_BITS;
   localparam int W_BITS    = FRAC_BITS + 8;
   localparam int M_BITS    = W_BITS + D_BITS;
   localparam int X_BITS    = W_BITS;
   localparam int DIV_SHIFT = X_BITS + 4;
   localparam int K_BITS    = X_BITS + 3;
   localparam int Q_BITS    = X_BITS + K_BITS;
   localparam int P_BITS    = SAMPLE_BITS + W_BITS;
   localparam int ACC_BITS  = P_BITS + 3;
   localparam int R_BITS    = ACC_BITS - FRAC_BITS;
   localparam int PAIRS     = LANES / 2;

   localparam logic [63:0] MAG3_FULL  = ((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3;
   localparam logic [63:0] MAG15_FULL = ((64'd1 << DIV_SHIFT) + 64'd14) / 64'd15;
   localparam logic [K_BITS-1:0] MAG3  = MAG3_FULL[K_BITS-1:0];
   localparam logic [K_BITS-1:0] MAG15 = MAG15_FULL[K_BITS-1:0];

   localparam logic [FRAC_BITS:0] P_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
   localparam logic signed [M_BITS-1:0]   HALF_M = M_BITS'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] HALF_A = ACC_BITS'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [R_BITS-1:0]   SAT_HI = (R_BITS'(1) <<< (SAMPLE_BITS - 1)) - R_BITS'(1);
   localparam logic signed [R_BITS-1:0]   SAT_LO = -SAT_HI - R_BITS'(1);

   logic [N_BITS-1:0]  points_ff;
   logic [NUM_STG-1:0] vld_ff;
   logic [NUM_STG-1:0] vld_in;
   logic [NUM_STG:0]   adv;

   logic signed [SAMPLE_BITS-1:0] smp_ff [ST_IN:ST_SMUL-1][LANES];
   logic signed [SAMPLE_BITS-1:0] smp_in [ST_IN:ST_SMUL-1][LANES];
   logic [N_BITS-1:0]             n_ff   [ST_IN:ST_SMUL-1];
   logic [N_BITS-1:0]             n_in   [ST_IN:ST_SMUL-1];
   logic [FRAC_BITS:0]            p_ff;
   logic [FRAC_BITS:0]            p_in;
   logic signed [D_BITS-1:0]      d_ff   [ST_D:ST_MUL_LAST-1][LANES];
   logic signed [D_BITS-1:0]      d_in   [ST_D:ST_MUL_LAST-1][LANES];
   logic signed [W_BITS-1:0]      w_ff   [ST_D:ST_MUL_LAST][LANES];
   logic signed [W_BITS-1:0]      w_in   [ST_D:ST_MUL_LAST][LANES];
   logic [X_BITS-1:0]             x_ff   [LANES];
   logic [X_BITS-1:0]             x_in   [LANES];
   odd_type                       odd_ff [LANES];
   odd_type                       odd_in [LANES];
   logic [LANES-1:0]              neg_ff;
   logic [LANES-1:0]              neg_in;
   logic signed [W_BITS-1:0]      wt_ff  [LANES];
   logic signed [W_BITS-1:0]      wt_in  [LANES];
   logic signed [P_BITS-1:0]      sp_ff  [LANES];
   logic signed [P_BITS-1:0]      sp_in  [LANES];
   logic signed [P_BITS:0]        ps_ff  [PAIRS];
   logic signed [P_BITS:0]        ps_in  [PAIRS];
   logic signed [R_BITS-1:0]      r_ff;
   logic signed [R_BITS-1:0]      r_in;
   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic signed [SAMPLE_BITS-1:0] value_in;
   logic                          clipped_ff;
   logic                          clipped_in;

   // configuration
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= RESET_POINTS;
      end else if (csr_chan.valid) begin
         points_ff <= clamp_points(csr_chan.num_points);
      end
   end

   // stage flow control
   always_comb begin
      adv[NUM_STG] = rsp_chan.ready;
      for (int k = NUM_STG - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in = {vld_ff[NUM_STG-2:0], req_chan.valid};
   end

   assign req_chan.ready = adv[ST_IN];
   assign rsp_chan.valid   = vld_ff[ST_OUT];
   assign rsp_chan.value   = value_ff;
   assign rsp_chan.clipped = clipped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STG; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // datapath
   always_comb begin
      logic [1:0]               x0n;
      logic signed [C_BITS-1:0] c;
      logic signed [M_BITS-1:0] prod;
      logic signed [M_BITS-1:0] rnd;
      logic [X_BITS-1:0]        absw;
      logic [X_BITS-1:0]        q;
      logic [K_BITS-1:0]        magic;
      logic [Q_BITS-1:0]        qp;
      logic signed [ACC_BITS-1:0] acc;
      den_type                  den;
      int                       m;
      int                       j;

      // input register: take samples and point count, clamp the fraction
      smp_in[ST_IN][0] = req_chan.sample_0;
      smp_in[ST_IN][1] = req_chan.sample_1;
      smp_in[ST_IN][2] = req_chan.sample_2;
      smp_in[ST_IN][3] = req_chan.sample_3;
      smp_in[ST_IN][4] = req_chan.sample_4;
      smp_in[ST_IN][5] = req_chan.sample_5;
      n_in[ST_IN]      = points_ff;
      p_in             = (req_chan.frac > P_ONE) ? P_ONE : req_chan.frac;

      for (int s = ST_IN + 1; s < ST_SMUL; s++) begin
         smp_in[s] = smp_ff[s-1];
         n_in[s]   = n_ff[s-1];
      end

      // node distances and first factor of each basis product
      x0n = node_offset(n_ff[ST_IN]);
      for (int jj = 0; jj < LANES; jj++) begin
         c = C_BITS'(x0n) - C_BITS'(jj);
         d_in[ST_D][jj] = D_BITS'(p_ff) + {c, {FRAC_BITS{1'b0}}};
      end
      for (int i = 0; i < LANES; i++) begin
         j = (i > 0) ? 0 : 1;
         w_in[ST_D][i] = W_BITS'(d_in[ST_D][j]);
      end

      for (int s = ST_D + 1; s < ST_MUL_LAST; s++) begin
         d_in[s] = d_ff[s-1];
      end

      // one further factor per stage, skipping the current lane's own node
      for (int s = ST_D + 1; s <= ST_MUL_LAST; s++) begin
         m = s - ST_D;
         for (int i = 0; i < LANES; i++) begin
            j    = (m < i) ? m : m + 1;
            prod = M_BITS'(w_ff[s-1][i]) * M_BITS'(d_ff[s-1][j]);
            rnd  = (prod + HALF_M) >>> FRAC_BITS;
            if (int'(n_ff[s-1]) > m + 1) begin
               w_in[s][i] = rnd[W_BITS-1:0];
            end else begin
               w_in[s][i] = w_ff[s-1][i];
            end
         end
      end

      // divide by |D|: round, drop the power of two, keep the odd part for later
      for (int i = 0; i < LANES; i++) begin
         den  = den_lookup(n_ff[ST_MUL_LAST], i);
         absw = w_ff[ST_MUL_LAST][i][W_BITS-1] ? X_BITS'(-w_ff[ST_MUL_LAST][i])
                                               : X_BITS'(w_ff[ST_MUL_LAST][i]);
         x_in[i]   = (absw + X_BITS'(den.half)) >> den.shift;
         odd_in[i] = den.odd;
         neg_in[i] = w_ff[ST_MUL_LAST][i][W_BITS-1] ^ den.neg;
      end

      // odd part by reciprocal multiply, then restore the sign
      for (int i = 0; i < LANES; i++) begin
         unique case (odd_ff[i])
            ODD_ONE:     magic = '0;
            ODD_THREE:   magic = MAG3;
            ODD_FIFTEEN: magic = MAG15;
         endcase
         qp = Q_BITS'(x_ff[i]) * Q_BITS'(magic);
         q  = (odd_ff[i] == ODD_ONE) ? x_ff[i] : X_BITS'(qp >> DIV_SHIFT);
         wt_in[i] = neg_ff[i] ? W_BITS'(-q) : W_BITS'(q);
      end

      // weight the samples, drop unused lanes
      for (int i = 0; i < LANES; i++) begin
         if (i < int'(n_ff[ST_SMUL-1])) begin
            sp_in[i] = P_BITS'(smp_ff[ST_SMUL-1][i]) * P_BITS'(wt_ff[i]);
         end else begin
            sp_in[i] = '0;
         end
      end

      for (int k = 0; k < PAIRS; k++) begin
         ps_in[k] = (P_BITS+1)'(sp_ff[2*k]) + (P_BITS+1)'(sp_ff[2*k+1]);
      end

      acc = HALF_A;
      for (int k = 0; k < PAIRS; k++) begin
         acc = acc + ACC_BITS'(ps_ff[k]);
      end
      r_in = R_BITS'(acc >>> FRAC_BITS);

      priority if (r_ff > SAT_HI) begin
         value_in   = SAT_HI[SAMPLE_BITS-1:0];
         clipped_in = 1'b1;
      end else if (r_ff < SAT_LO) begin
         value_in   = SAT_LO[SAMPLE_BITS-1:0];
         clipped_in = 1'b1;
      end else begin
         value_in   = r_ff[SAMPLE_BITS-1:0];
         clipped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = ST_IN; s < ST_SMUL; s++) begin
         if (adv[s]) begin
            smp_ff[s] <= smp_in[s];
            n_ff[s]   <= n_in[s];
         end
      end
      if (adv[ST_IN]) begin
         p_ff <= p_in;
      end
      for (int s = ST_D; s < ST_MUL_LAST; s++) begin
         if (adv[s]) begin
            d_ff[s] <= d_in[s];
         end
      end
      for (int s = ST_D; s <= ST_MUL_LAST; s++) begin
         if (adv[s]) begin
            w_ff[s] <= w_in[s];
         end
      end
      if (adv[ST_DIVP]) begin
         x_ff   <= x_in;
         odd_ff <= odd_in;
         neg_ff <= neg_in;
      end
      if (adv[ST_DIV]) begin
         wt_ff <= wt_in;
      end
      if (adv[ST_SMUL]) begin
         sp_ff <= sp_in;
      end
      if (adv[ST_PAIR]) begin
         ps_ff <= ps_in;
      end
      if (adv[ST_SUM]) begin
         r_ff <= r_in;
      end
      if (adv[ST_OUT]) begin
         value_ff   <= value_in;
         clipped_ff <= clipped_in;
      end
   end

endmodule
